// ===== rtl/tpct_pkg.sv =====
// ----------------------------------------------------------------------------
// tpct_pkg
// Shared types and constants of the transport stream PID continuity tracker.
// ----------------------------------------------------------------------------
package tpct_pkg;

   // table geometry
   localparam int PID_COUNT = 8192;
   localparam int PID_W     = 13;
   localparam int IDX_W     = (PID_COUNT > 1) ? $clog2(PID_COUNT) : 1;
   localparam logic [PID_W:0] PID_LIMIT = (PID_W + 1)'(PID_COUNT);

   // field widths
   localparam int CMD_W   = 3;
   localparam int CC_W    = 4;
   localparam int COUNT_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_PACKET        = 3'd0,
      CMD_SET_USED      = 3'd1,
      CMD_SET_ALL       = 3'd2,
      CMD_RESET_ENTRY   = 3'd3,
      CMD_CLEAR_CHANGED = 3'd4,
      CMD_QUERY         = 3'd5
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] packet_count;
      logic [COUNT_W-1:0] error_count;
      logic [CC_W-1:0]    last_cc;
      logic               cc_valid;
      logic               used;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic read;
      logic commit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

// ===== rtl/tpct_ram.sv =====
// ----------------------------------------------------------------------------
// tpct_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tpct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tpct_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpct_ctrl
// Controller: clearing pass after reset, then read and update per request.
// ----------------------------------------------------------------------------
module tpct_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output tpct_pkg::dp_cmd_type    dp_cmd,
   input  tpct_pkg::dp_status_type dp_status
);

   import tpct_pkg::*;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (dp_status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      dp_cmd = '0;
      busy   = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            busy           = 1'b0;
            dp_cmd.capture = start;
         end
         ST_READ: begin
            dp_cmd.read = 1'b1;
         end
         ST_UPDATE: begin
            dp_cmd.commit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // a request is only taken after the table has been swept clear
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.capture |-> (state_ff == ST_IDLE))
      else $error("request captured outside idle");

   // every captured request is read and then written back
   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.capture |=> dp_cmd.read ##1 dp_cmd.commit)
      else $error("read or update did not follow capture");

   // sweep ends only from the clearing state
   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && dp_status.clear_last) |=> (state_ff == ST_IDLE))
      else $error("clearing pass did not end in idle");

endmodule

// ===== rtl/tpct_datapath.sv =====
// ----------------------------------------------------------------------------
// tpct_datapath
// Request registers, entry table, entry update and result registers.
// ----------------------------------------------------------------------------
module tpct_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  tpct_pkg::dp_cmd_type          dp_cmd,
   output tpct_pkg::dp_status_type       dp_status,
   input  logic [tpct_pkg::CMD_W-1:0]    req_command,
   input  logic [tpct_pkg::PID_W-1:0]    req_pid,
   input  logic [tpct_pkg::CC_W-1:0]     req_cont_count,
   input  logic                          req_used_value,
   output logic                          rsp_valid,
   output logic [tpct_pkg::COUNT_W-1:0]  rsp_packet_count,
   output logic [tpct_pkg::COUNT_W-1:0]  rsp_error_count,
   output logic                          rsp_pid_used,
   output logic                          rsp_all_used,
   output logic                          rsp_table_changed
);

   import tpct_pkg::*;

   // request registers
   logic [CMD_W-1:0]   cmd_ff;
   logic [PID_W-1:0]   pid_ff;
   logic [CC_W-1:0]    cc_ff;
   logic               val_ff;

   // control registers
   logic [IDX_W-1:0]   clr_cnt_ff;
   logic               all_used_ff;
   logic               all_used_in;
   logic               changed_ff;
   logic               changed_in;
   logic               rsp_valid_ff;

   // result registers
   logic [COUNT_W-1:0] rsp_pkt_ff;
   logic [COUNT_W-1:0] rsp_err_ff;
   logic               rsp_used_ff;

   // table access
   logic               in_table;
   logic [IDX_W-1:0]   pid_idx;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          old_entry;
   entry_type          new_entry;
   logic [CC_W-1:0]    expected_cc;
   logic [CC_W-1:0]    gap;

   assign in_table   = ({1'b0, pid_ff} < PID_LIMIT);
   assign pid_idx    = pid_ff[IDX_W-1:0];
   assign old_entry  = entry_type'(rd_data);

   // latch the request
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff <= req_command;
         pid_ff <= req_pid;
         cc_ff  <= req_cont_count;
         val_ff <= req_used_value;
      end
   end

   // advance the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (dp_cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign dp_status.clear_last = (clr_cnt_ff == IDX_W'(PID_COUNT - 1));

   // continuity check: gap is zero exactly when the counter is as expected
   assign expected_cc = old_entry.last_cc + 1'b1;
   assign gap         = cc_ff - expected_cc;

   // modify the entry and the global flags
   always_comb begin
      new_entry   = old_entry;
      all_used_in = all_used_ff;
      changed_in  = changed_ff;
      case (cmd_type'(cmd_ff))
         CMD_PACKET: begin
            new_entry.packet_count = old_entry.packet_count + 1'b1;
            if (old_entry.cc_valid) begin
               new_entry.error_count = old_entry.error_count
                                       + {{(COUNT_W - CC_W){1'b0}}, gap};
            end
            new_entry.last_cc  = cc_ff;
            new_entry.cc_valid = 1'b1;
         end
         CMD_SET_USED: begin
            new_entry.used = val_ff;
            if (in_table) begin
               changed_in = 1'b1;
            end
         end
         CMD_SET_ALL: begin
            all_used_in = val_ff;
            changed_in  = 1'b1;
         end
         CMD_RESET_ENTRY: begin
            new_entry = '0;
         end
         CMD_CLEAR_CHANGED: begin
            changed_in = 1'b0;
         end
         CMD_QUERY: begin
            new_entry = old_entry;
         end
         default: begin
            new_entry = old_entry;
         end
      endcase
   end

   // write port: sweep zeros, else write the updated entry back
   assign wr_en   = dp_cmd.clear_step | (dp_cmd.commit & in_table);
   assign wr_addr = dp_cmd.clear_step ? clr_cnt_ff : pid_idx;
   assign wr_data = dp_cmd.clear_step ? '0 : ENTRY_W'(new_entry);

   tpct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PID_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (dp_cmd.read),
      .rd_addr (pid_idx),
      .rd_data (rd_data)
   );

   // global flags
   always_ff @(posedge clock) begin
      if (reset) begin
         all_used_ff <= 1'b0;
         changed_ff  <= 1'b0;
      end else if (dp_cmd.commit) begin
         all_used_ff <= all_used_in;
         changed_ff  <= changed_in;
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dp_cmd.commit;
      end
   end

   // result payload, zero for a pid outside the table
   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         rsp_pkt_ff  <= in_table ? new_entry.packet_count : '0;
         rsp_err_ff  <= in_table ? new_entry.error_count : '0;
         rsp_used_ff <= in_table & new_entry.used;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packet_count  = rsp_pkt_ff;
   assign rsp_error_count   = rsp_err_ff;
   assign rsp_pid_used      = rsp_used_ff;
   assign rsp_all_used      = all_used_ff;
   assign rsp_table_changed = changed_ff;

   // one request yields exactly one result, registered from the update that follows its read
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.read |=> !rsp_valid ##1 rsp_valid)
      else $error("result strobe out of step with read");

   // the sweep never overlaps request traffic
   a_sweep_alone: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.clear_step |-> !(dp_cmd.commit || dp_cmd.read || dp_cmd.capture))
      else $error("clearing pass overlaps a request");

   // the changed flag only rises on a flag write
   a_changed_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(changed_ff) |-> ($past(dp_cmd.commit)
         && ($past(cmd_ff) == CMD_SET_USED || $past(cmd_ff) == CMD_SET_ALL)))
      else $error("changed flag raised without a flag write");

endmodule

// ===== rtl/ts_pid_continuity_tracker.sv =====
// ----------------------------------------------------------------------------
// ts_pid_continuity_tracker
// Per-PID packet and continuity error table for a transport stream.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 8192-entry table (PID_COUNT entries) to
// zero, one entry a cycle, and holds busy high until the sweep is done. Then
// each request is taken when start is high and busy low: the entry is read
// from the table memory, then updated and written back, and the block then
// returns to idle, where the next request can be taken; no new request is
// taken before the last one is through. The result, registered from the
// update, appears on the rsp_ ports for a single cycle with rsp_valid high;
// the receiver must take it then, as there is no way to hold it off.
// ----------------------------------------------------------------------------
module ts_pid_continuity_tracker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tpct_pkg::CMD_W-1:0]    req_command,
   input  logic [tpct_pkg::PID_W-1:0]    req_pid,
   input  logic [tpct_pkg::CC_W-1:0]     req_cont_count,
   input  logic                          req_used_value,
   output logic                          rsp_valid,
   output logic [tpct_pkg::COUNT_W-1:0]  rsp_packet_count,
   output logic [tpct_pkg::COUNT_W-1:0]  rsp_error_count,
   output logic                          rsp_pid_used,
   output logic                          rsp_all_used,
   output logic                          rsp_table_changed
);

   import tpct_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tpct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   tpct_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .req_command       (req_command),
      .req_pid           (req_pid),
      .req_cont_count    (req_cont_count),
      .req_used_value    (req_used_value),
      .rsp_valid         (rsp_valid),
      .rsp_packet_count  (rsp_packet_count),
      .rsp_error_count   (rsp_error_count),
      .rsp_pid_used      (rsp_pid_used),
      .rsp_all_used      (rsp_all_used),
      .rsp_table_changed (rsp_table_changed)
   );

   // a taken request keeps the block busy until its result is out
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 busy ##1 (!busy && rsp_valid))
      else $error("busy did not cover the request");

   // the block is busy sweeping right after reset
   a_busy_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("not busy after reset");

   // a result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

endmodule

// ===== bench/ts_pid_continuity_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// ts_pid_continuity_tracker_tb
// Self-checking bench for the per-PID continuity tracker. A short table of
// directed requests covers the table edges, every command, duplicate and
// skipped counters, entry reset and the spare command codes. Random traffic
// follows: mostly clean counter runs on a few busy PIDs with gaps, repeats and
// stray commands mixed in. Each response is checked field by field against a
// hand-worked value (edge rows) or a behavioural copy of the table in the bench.
// ----------------------------------------------------------------------------
module ts_pid_continuity_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tpct_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
   localparam logic [PID_W-1:0] PID_TOP     = PID_W'(PID_COUNT - 1);
   localparam int RANDOM_REQUESTS = 1650;
   localparam int STALL_LIMIT     = 40000;

   typedef struct packed {
      logic [COUNT_W-1:0] packet_count;
      logic [COUNT_W-1:0] error_count;
      logic               pid_used;
      logic               all_used;
      logic               table_changed;
   } entry_report_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [PID_W-1:0] pid;
      logic [CC_W-1:0]  cont_count;
      logic             used_value;
      logic             fixed;
      entry_report_type report;
   } request_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_command = '0;
   logic [PID_W-1:0]    req_pid = '0;
   logic [CC_W-1:0]     req_cont_count = '0;
   logic                req_used_value = 1'b0;
   logic                rsp_valid;
   logic [COUNT_W-1:0]  rsp_packet_count;
   logic [COUNT_W-1:0]  rsp_error_count;
   logic                rsp_pid_used;
   logic                rsp_all_used;
   logic                rsp_table_changed;

   // shadow of the PID table and the global flags
   entry_type        pid_entries [PID_COUNT];
   logic             all_pids_shadow;
   logic             changed_shadow;
   entry_report_type pending_reports [$];
   logic [PID_W-1:0] busy_pids [8];
   int               mismatch_count = 0;
   int               stall_cycles = 0;
   int               burst_left = 0;

   // edge rows carry a hand-worked response, the rest go through the shadow
   request_type directed_rows [0:22] = '{
      '{CMD_QUERY,         13'd0,    4'd0,  1'b0, 1'b1, '{32'd0, 32'd0,  1'b0, 1'b0, 1'b0}},
      '{CMD_QUERY,         PID_TOP,  4'd15, 1'b1, 1'b1, '{32'd0, 32'd0,  1'b0, 1'b0, 1'b0}},
      '{CMD_PACKET,        PID_TOP,  4'd15, 1'b0, 1'b1, '{32'd1, 32'd0,  1'b0, 1'b0, 1'b0}},
      '{CMD_PACKET,        PID_TOP,  4'd0,  1'b0, 1'b1, '{32'd2, 32'd0,  1'b0, 1'b0, 1'b0}},
      '{CMD_PACKET,        PID_TOP,  4'd0,  1'b1, 1'b1, '{32'd3, 32'd15, 1'b0, 1'b0, 1'b0}},
      '{CMD_PACKET,        PID_TOP,  4'd5,  1'b0, 1'b1, '{32'd4, 32'd19, 1'b0, 1'b0, 1'b0}},
      '{CMD_PACKET,        13'd0,    4'd0,  1'b0, 1'b1, '{32'd1, 32'd0,  1'b0, 1'b0, 1'b0}},
      '{CMD_SET_USED,      13'd0,    4'd0,  1'b1, 1'b1, '{32'd1, 32'd0,  1'b1, 1'b0, 1'b1}},
      '{CMD_CLEAR_CHANGED, 13'd0,    4'd9,  1'b1, 1'b1, '{32'd1, 32'd0,  1'b1, 1'b0, 1'b0}},
      '{CMD_SET_ALL,       PID_TOP,  4'd0,  1'b1, 1'b1, '{32'd4, 32'd19, 1'b0, 1'b1, 1'b1}},
      '{CMD_SET_USED,      PID_TOP,  4'd0,  1'b0, 1'b1, '{32'd4, 32'd19, 1'b0, 1'b1, 1'b1}},
      '{CMD_CLEAR_CHANGED, PID_TOP,  4'd0,  1'b0, 1'b1, '{32'd4, 32'd19, 1'b0, 1'b1, 1'b0}},
      '{CMD_SET_ALL,       13'd0,    4'd0,  1'b0, 1'b1, '{32'd1, 32'd0,  1'b1, 1'b0, 1'b1}},
      '{CMD_SPARE_6,       13'd0,    4'd15, 1'b1, 1'b1, '{32'd1, 32'd0,  1'b1, 1'b0, 1'b1}},
      '{CMD_SPARE_7,       PID_TOP,  4'd15, 1'b0, 1'b1, '{32'd4, 32'd19, 1'b0, 1'b0, 1'b1}},
      '{CMD_RESET_ENTRY,   PID_TOP,  4'd0,  1'b1, 1'b1, '{32'd0, 32'd0,  1'b0, 1'b0, 1'b1}},
      '{CMD_PACKET,        PID_TOP,  4'd7,  1'b0, 1'b1, '{32'd1, 32'd0,  1'b0, 1'b0, 1'b1}},
      '{CMD_RESET_ENTRY,   13'd0,    4'd0,  1'b0, 1'b1, '{32'd0, 32'd0,  1'b0, 1'b0, 1'b1}},
      '{CMD_QUERY,         13'd0,    4'd15, 1'b1, 1'b1, '{32'd0, 32'd0,  1'b0, 1'b0, 1'b1}},
      '{CMD_PACKET,        13'h0AAA, 4'd10, 1'b0, 1'b0, '0},
      '{CMD_PACKET,        13'h1555, 4'd5,  1'b1, 1'b0, '0},
      '{CMD_SET_USED,      13'h1555, 4'd3,  1'b1, 1'b0, '0},
      '{CMD_CLEAR_CHANGED, 13'h0AAA, 4'd12, 1'b0, 1'b0, '0}
   };

   ts_pid_continuity_tracker i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_pid           (req_pid),
      .req_cont_count    (req_cont_count),
      .req_used_value    (req_used_value),
      .rsp_valid         (rsp_valid),
      .rsp_packet_count  (rsp_packet_count),
      .rsp_error_count   (rsp_error_count),
      .rsp_pid_used      (rsp_pid_used),
      .rsp_all_used      (rsp_all_used),
      .rsp_table_changed (rsp_table_changed)
   );

   always #1 clock = ~clock;

   // apply one request to the shadow table and return the entry it reports
   function automatic entry_report_type update_pid_entry(request_type rq);
      entry_report_type rep;
      logic             in_range;
      logic [CC_W-1:0]  next_cc;
      logic [CC_W-1:0]  gap;
      in_range = ({1'b0, rq.pid} < PID_LIMIT);
      if (rq.command == CMD_SET_ALL) begin
         all_pids_shadow = rq.used_value;
         changed_shadow  = 1'b1;
      end else if (rq.command == CMD_CLEAR_CHANGED) begin
         changed_shadow = 1'b0;
      end else if (in_range) begin
         case (rq.command)
            CMD_PACKET: begin
               pid_entries[rq.pid].packet_count = pid_entries[rq.pid].packet_count + 1;
               if (pid_entries[rq.pid].cc_valid) begin
                  next_cc = pid_entries[rq.pid].last_cc + 1'b1;
                  gap     = rq.cont_count - next_cc;
                  pid_entries[rq.pid].error_count = pid_entries[rq.pid].error_count + gap;
               end
               pid_entries[rq.pid].last_cc  = rq.cont_count;
               pid_entries[rq.pid].cc_valid = 1'b1;
            end
            CMD_SET_USED: begin
               pid_entries[rq.pid].used = rq.used_value;
               changed_shadow = 1'b1;
            end
            CMD_RESET_ENTRY: pid_entries[rq.pid] = '0;
            default: ;
         endcase
      end
      rep = '0;
      if (in_range) begin
         rep.packet_count = pid_entries[rq.pid].packet_count;
         rep.error_count  = pid_entries[rq.pid].error_count;
         rep.pid_used     = pid_entries[rq.pid].used;
      end
      rep.all_used      = all_pids_shadow;
      rep.table_changed = changed_shadow;
      return rep;
   endfunction

   // build a random request: mostly clean counter runs on the busy PIDs
   function automatic request_type random_request();
      request_type rq;
      int          roll;
      rq = '0;
      if ($urandom_range(0, 99) < 80) rq.pid = busy_pids[$urandom_range(0, 7)];
      else                            rq.pid = PID_W'($urandom_range(0, PID_COUNT - 1));
      roll = $urandom_range(0, 99);
      if      (roll < 70) rq.command = CMD_PACKET;
      else if (roll < 76) rq.command = CMD_SET_USED;
      else if (roll < 80) rq.command = CMD_SET_ALL;
      else if (roll < 83) rq.command = CMD_RESET_ENTRY;
      else if (roll < 89) rq.command = CMD_CLEAR_CHANGED;
      else if (roll < 96) rq.command = CMD_QUERY;
      else if (roll < 98) rq.command = CMD_SPARE_6;
      else                rq.command = CMD_SPARE_7;
      if (rq.command == CMD_PACKET && $urandom_range(0, 99) < 85)
         rq.cont_count = pid_entries[rq.pid].last_cc + 1'b1;
      else
         rq.cont_count = CC_W'($urandom_range(0, 15));
      rq.used_value = 1'($urandom_range(0, 1));
      return rq;
   endfunction

   // hold the request until taken, then log what it should report
   task automatic issue_request(request_type rq);
      entry_report_type predicted;
      start          <= 1'b1;
      req_command    <= rq.command;
      req_pid        <= rq.pid;
      req_cont_count <= rq.cont_count;
      req_used_value <= rq.used_value;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = update_pid_entry(rq);
      pending_reports.push_back(rq.fixed ? rq.report : predicted);
   endtask

   // send in bursts, with an occasional idle gap between them
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic check_field(string field, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // compare each response with the oldest outstanding request
   always @(posedge clock) begin
      entry_report_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_reports.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with no request outstanding, expected none, actual %0d/%0d",
                     $time, rsp_packet_count, rsp_error_count);
         end else begin
            want = pending_reports.pop_front();
            check_field("packet_count", want.packet_count, rsp_packet_count);
            check_field("error_count", want.error_count, rsp_error_count);
            check_field("pid_used", COUNT_W'(want.pid_used), COUNT_W'(rsp_pid_used));
            check_field("all_used", COUNT_W'(want.all_used), COUNT_W'(rsp_all_used));
            check_field("table_changed", COUNT_W'(want.table_changed),
                        COUNT_W'(rsp_table_changed));
         end
      end
   end

   // abort when neither side makes progress for too long
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      foreach (pid_entries[i]) pid_entries[i] = '0;
      all_pids_shadow = 1'b0;
      changed_shadow  = 1'b0;
      busy_pids[0] = '0;
      busy_pids[1] = PID_TOP;
      for (int i = 2; i < 8; i++) busy_pids[i] = PID_W'($urandom_range(0, PID_COUNT - 1));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed edges and commands
      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i]);
         pace_sender();
      end

      // random traffic, with one full drain half way through
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         issue_request(random_request());
         if (n == RANDOM_REQUESTS / 2) begin
            start <= 1'b0;
            while (pending_reports.size() != 0) @(posedge clock);
         end
         pace_sender();
      end

      // drain and watch for stray responses
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tpct_pkg.sv
rtl/tpct_ram.sv
rtl/tpct_ctrl.sv
rtl/tpct_datapath.sv
rtl/ts_pid_continuity_tracker.sv
bench/ts_pid_continuity_tracker_tb.sv
